@@ sv/wrca_pkg.sv @@
// Shared types, constants and helper functions for the wind reply checker and alarm.
package wrca_pkg;

  // Reply frame layout
  localparam int unsigned FRAME_BYTES = 7;
  localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;
  localparam logic [7:0] ADDR_POS = 8'd0;
  localparam logic [7:0] SPEED_HI_POS = 8'd3;
  localparam logic [7:0] SPEED_LO_POS = 8'd4;

  // CRC-16/MODBUS, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Beaufort limits in tenths of m/s
  localparam int unsigned LIMIT_COUNT = 12;
  localparam logic [3:0] HURRICANE_LEVEL = 4'd12;
  localparam logic [3:0] MAX_ALARM_IDX = 4'd11;
  localparam logic [15:0] LEVEL_LIMIT [LIMIT_COUNT] = '{
    16'd5, 16'd15, 16'd33, 16'd55, 16'd79, 16'd107,
    16'd138, 16'd171, 16'd207, 16'd244, 16'd284, 16'd326
  };

  // Register reset values
  localparam logic [7:0] DEV_ADDR_RESET = 8'd1;
  localparam logic [3:0] ALARM_IDX_RESET = 4'd6;
  localparam logic [31:0] HOLD_TICKS_RESET = 32'd1000;

  // Input word kinds
  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_MISSING = 2'd1,
    ACT_TICK    = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_ALARM_IDX  = 2'd1,
    CFG_HOLD_TICKS = 2'd2
  } cfg_reg_e;

  // One input word
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       last_byte;
    logic       server_control;
  } in_word_t;

  // Frame checker verdict for the word being processed
  typedef struct packed {
    logic        poll;
    logic        good;
    logic [15:0] speed;
  } frame_res_t;

  // One result word
  typedef struct packed {
    logic        sensor_present;
    logic [15:0] speed_tenths;
    logic [3:0]  beaufort_level;
    logic        alarm_mode;
  } out_word_t;

  // One byte through the CRC, bit by bit
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // First level whose limit is not below the speed, else hurricane
  function automatic logic [3:0] level_of(logic [15:0] tenths);
    logic [3:0] lvl;
    lvl = HURRICANE_LEVEL;
    for (int k = LIMIT_COUNT - 1; k >= 0; k--) begin
      if (tenths <= LEVEL_LIMIT[k]) lvl = 4'(k);
    end
    return lvl;
  endfunction

endpackage

@@ sv/wrca_in_stage.sv @@
// Input register stage: holds one accepted word until the core takes it.
module wrca_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  wrca_pkg::in_word_t word_i,
  output logic               ready_o,
  input  logic               take_i,
  output logic               valid_o,
  output wrca_pkg::in_word_t word_o
);

  logic               valid_q;
  wrca_pkg::in_word_t word_q;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

@@ sv/wrca_frame_check.sv @@
// Reply frame checker: running CRC, byte count, address match and speed bytes.
module wrca_frame_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  wrca_pkg::in_word_t   word_i,
  input  logic [7:0]           dev_addr_i,
  output wrca_pkg::frame_res_t frame_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        addr_ok_q, addr_ok_d;
  logic [7:0]  spd_hi_q, spd_hi_d;
  logic [7:0]  spd_lo_q, spd_lo_d;
  logic        is_byte;
  logic        poll;

  // Frame state after taking this byte
  always_comb begin
    crc_d     = wrca_pkg::crc_step(crc_q, word_i.rx_byte);
    cnt_d     = (cnt_q == wrca_pkg::BYTE_COUNT_MAX) ? cnt_q : cnt_q + 8'd1;
    addr_ok_d = (cnt_q == wrca_pkg::ADDR_POS) ? (word_i.rx_byte == dev_addr_i) : addr_ok_q;
    spd_hi_d  = (cnt_q == wrca_pkg::SPEED_HI_POS) ? word_i.rx_byte : spd_hi_q;
    spd_lo_d  = (cnt_q == wrca_pkg::SPEED_LO_POS) ? word_i.rx_byte : spd_lo_q;
  end

  // A poll ends on the last byte or on a missing reply
  assign is_byte = (word_i.action == wrca_pkg::ACT_BYTE);
  assign poll    = (is_byte && word_i.last_byte) || (word_i.action == wrca_pkg::ACT_MISSING);

  assign frame_o.poll  = poll;
  assign frame_o.good  = is_byte && (cnt_d == 8'(wrca_pkg::FRAME_BYTES)) && addr_ok_d &&
                         (crc_d == 16'h0000);
  assign frame_o.speed = {spd_hi_d, spd_lo_d};

  // Frame registers: restart after every poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= wrca_pkg::CRC_INIT;
      cnt_q     <= '0;
      addr_ok_q <= 1'b0;
      spd_hi_q  <= '0;
      spd_lo_q  <= '0;
    end else if (fire_i) begin
      if (poll) begin
        crc_q     <= wrca_pkg::CRC_INIT;
        cnt_q     <= '0;
        addr_ok_q <= 1'b0;
        spd_hi_q  <= '0;
        spd_lo_q  <= '0;
      end else if (is_byte) begin
        crc_q     <= crc_d;
        cnt_q     <= cnt_d;
        addr_ok_q <= addr_ok_d;
        spd_hi_q  <= spd_hi_d;
        spd_lo_q  <= spd_lo_d;
      end
    end
  end

endmodule

@@ sv/wrca_alarm.sv @@
// Held speed and level, tick counter, and exception mode with its clear deadline.
module wrca_alarm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  wrca_pkg::in_word_t   word_i,
  input  wrca_pkg::frame_res_t frame_i,
  input  logic [3:0]           alarm_idx_i,
  input  logic [31:0]          hold_ticks_i,
  output wrca_pkg::out_word_t  result_o
);

  logic [15:0] held_speed_q, held_speed_d;
  logic [3:0]  held_level_q, held_level_d;
  logic        mode_q, mode_d;
  logic [31:0] deadline_q, deadline_d;
  logic [31:0] tick_q;
  logic [3:0]  idx;
  logic        over;
  logic        mode_set;
  logic [31:0] deadline_set;
  logic        clear;

  // Poll outcome
  always_comb begin
    held_speed_d = frame_i.good ? frame_i.speed : held_speed_q;
    held_level_d = frame_i.good ? wrca_pkg::level_of(frame_i.speed) : held_level_q;
    idx          = (alarm_idx_i > wrca_pkg::MAX_ALARM_IDX) ? wrca_pkg::MAX_ALARM_IDX
                                                           : alarm_idx_i;
    over         = (held_speed_d >= wrca_pkg::LEVEL_LIMIT[idx]);
    mode_set     = mode_q || over;
    deadline_set = over ? (tick_q + hold_ticks_i) : deadline_q;
    clear        = (tick_q > deadline_set) && word_i.server_control;
    mode_d       = clear ? 1'b0 : mode_set;
    deadline_d   = clear ? '0 : deadline_set;
  end

  assign result_o.sensor_present = frame_i.good;
  assign result_o.speed_tenths   = held_speed_d;
  assign result_o.beaufort_level = held_level_d;
  assign result_o.alarm_mode     = mode_d;

  // Commit on a poll; ticks advance the time base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_speed_q <= '0;
      held_level_q <= '0;
      mode_q       <= 1'b0;
      deadline_q   <= '0;
      tick_q       <= '0;
    end else if (fire_i) begin
      if (frame_i.poll) begin
        held_speed_q <= held_speed_d;
        held_level_q <= held_level_d;
        mode_q       <= mode_d;
        deadline_q   <= deadline_d;
      end else if (word_i.action == wrca_pkg::ACT_TICK) begin
        tick_q <= tick_q + 32'd1;
      end
    end
  end

endmodule

@@ sv/wind_reply_check_and_alarm.sv @@
// Top level: wind sensor reply checker with wind alarm and exception mode.
//
// Input stream (s_axis_*): one word per reply byte, missing reply or timer tick.
//   tuser carries the word kind, tlast marks the final byte of a reply frame,
//   tdata carries the byte and the server control flag.
// Output stream (m_axis_*): one word per poll (frame end or missing reply):
//   sensor present, held speed in tenths of m/s, Beaufort level, exception mode.
// Configuration (cfg_*): index and data, always ready; it must be written
//   only while idle, which the user ensures; the block has no check for it.
// A word is processed from the input register into the output register.
// Throughput: one word per cycle, stalls aside; CRC byte step, level ladder
//   and deadline add/compare all fit between the input and output register.
// Reset: frame state restarts, held speed and level are zero, normal mode,
//   tick counter and deadline zero, registers take their default values.
// Stall: while a result waits, words without a result still flow; a word that
//   ends a poll waits in the input register, and s_axis_tready drops only then.
module wind_reply_check_and_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [8] server_control, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  input  logic        s_axis_tlast,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] sensor_present, [16:1] speed_tenths, [20:17] beaufort_level,
  // [21] alarm_mode, rest zero
  output logic [23:0] m_axis_tdata,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  wrca_pkg::in_word_t   s_word;
  wrca_pkg::in_word_t   word;
  wrca_pkg::frame_res_t frame;
  wrca_pkg::out_word_t  result;
  wrca_pkg::out_word_t  out_q;
  logic                 out_valid_q;
  logic                 word_valid;
  logic                 fire;
  logic [7:0]           dev_addr_q;
  logic [3:0]           alarm_idx_q;
  logic [31:0]          hold_ticks_q;

  // Unpack the input word
  assign s_word.action         = s_axis_tuser;
  assign s_word.rx_byte        = s_axis_tdata[7:0];
  assign s_word.last_byte      = s_axis_tlast;
  assign s_word.server_control = s_axis_tdata[8];

  wrca_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .word_i  (s_word),
    .ready_o (s_axis_tready),
    .take_i  (fire),
    .valid_o (word_valid),
    .word_o  (word)
  );

  // Process the held word unless its result has nowhere to go
  assign fire = word_valid && (!frame.poll || !out_valid_q || m_axis_tready);

  wrca_frame_check u_frame_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .word_i     (word),
    .dev_addr_i (dev_addr_q),
    .frame_o    (frame)
  );

  wrca_alarm u_alarm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .word_i       (word),
    .frame_i      (frame),
    .alarm_idx_i  (alarm_idx_q),
    .hold_ticks_i (hold_ticks_q),
    .result_o     (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && frame.poll) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && frame.poll) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.alarm_mode, out_q.beaufort_level,
                          out_q.speed_tenths, out_q.sensor_present};

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= wrca_pkg::DEV_ADDR_RESET;
      alarm_idx_q  <= wrca_pkg::ALARM_IDX_RESET;
      hold_ticks_q <= wrca_pkg::HOLD_TICKS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wrca_pkg::CFG_DEV_ADDR:   dev_addr_q   <= cfg_data_i[7:0];
        wrca_pkg::CFG_ALARM_IDX:  alarm_idx_q  <= cfg_data_i[3:0];
        wrca_pkg::CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shown level always matches the shown speed
  a_level_matches_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.beaufort_level == wrca_pkg::level_of(out_q.speed_tenths)))
    else $error("beaufort level does not match held speed");

  // Every processed poll yields a result in the next cycle
  a_poll_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && frame.poll) |=> out_valid_q)
    else $error("poll processed without a result");

  // A missing reply never reports the sensor as present
  a_missing_is_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (word.action == wrca_pkg::ACT_MISSING)) |=> !out_q.sensor_present)
    else $error("missing reply reported as present");

  // Input back-pressure only while a word is held
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (word_valid && frame.poll && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the wind sensor reply checker and wind alarm.
`timescale 1ns / 100ps

module tb_top;
  import wrca_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Kind code the block ignores; it has no member in the package enum
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  // Modbus read-holding-registers reply header
  localparam logic [7:0] READ_FUNC = 8'h03;
  localparam logic [7:0] REPLY_DATA_LEN = 8'h02;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_WORDS = 90;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MISMATCH_PRINT_MAX = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] rx_byte, [8] server_control
  logic [1:0]  s_axis_tuser = '0;   // [1:0] action
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [0] present, [16:1] speed, [20:17] level, [21] mode
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  wind_reply_check_and_alarm dut (.*);

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow of the register file
  logic [7:0]  cfg_dev_addr = DEV_ADDR_RESET;
  logic [3:0]  cfg_alarm_idx = ALARM_IDX_RESET;
  logic [31:0] cfg_hold_ticks = HOLD_TICKS_RESET;

  // Shadow of the frame checker and alarm state
  logic [15:0] frame_crc = CRC_INIT;
  logic [7:0]  frame_len = '0;
  logic        frame_addr_hit = 1'b0;
  logic [7:0]  speed_hi_q = '0;
  logic [7:0]  speed_lo_q = '0;
  logic [15:0] shown_speed = '0;
  logic [3:0]  shown_level = '0;
  logic        alarm_on = 1'b0;
  logic [31:0] alarm_deadline = '0;
  logic [31:0] tick_count = '0;

  in_word_t  pending_words[$];
  out_word_t expected_reports[$];
  int        queued_count = 0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  // Traffic shaping
  bit sender_steady = 1'b0;
  bit long_hold_req = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  bit drive_valid;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_mode = 0;
  bit take_next;

  // CRC-16/MODBUS, one bit of the byte per pass, LSB first
  function automatic logic [15:0] mb_crc_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int n = 0; n < 8; n++) begin
      fb = r[0] ^ data[n];
      r = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [3:0] beaufort_of(input logic [15:0] tenths);
    for (int k = 0; k < LIMIT_COUNT; k++) begin
      if (tenths <= LEVEL_LIMIT[k]) return 4'(k);
    end
    return HURRICANE_LEVEL;
  endfunction

  function automatic logic [3:0] alarm_slot();
    return (cfg_alarm_idx > MAX_ALARM_IDX) ? MAX_ALARM_IDX : cfg_alarm_idx;
  endfunction

  // Poll end: latch speed on a good frame, run the alarm, queue the report
  task automatic close_poll(input bit good, input bit server);
    out_word_t rep;
    if (good) begin
      shown_speed = {speed_hi_q, speed_lo_q};
      shown_level = beaufort_of(shown_speed);
    end
    if (shown_speed >= LEVEL_LIMIT[alarm_slot()]) begin
      alarm_on = 1'b1;
      alarm_deadline = tick_count + cfg_hold_ticks;
    end
    if (tick_count > alarm_deadline && server) begin
      alarm_on = 1'b0;
      alarm_deadline = '0;
    end
    frame_crc = CRC_INIT;
    frame_len = '0;
    frame_addr_hit = 1'b0;
    speed_hi_q = '0;
    speed_lo_q = '0;
    rep.sensor_present = good;
    rep.speed_tenths = shown_speed;
    rep.beaufort_level = shown_level;
    rep.alarm_mode = alarm_on;
    expected_reports.push_back(rep);
  endtask

  task automatic step_wind_model(input in_word_t w);
    case (w.action)
      ACT_BYTE: begin
        frame_crc = mb_crc_byte(frame_crc, w.rx_byte);
        if (frame_len == ADDR_POS) frame_addr_hit = (w.rx_byte == cfg_dev_addr);
        else if (frame_len == SPEED_HI_POS) speed_hi_q = w.rx_byte;
        else if (frame_len == SPEED_LO_POS) speed_lo_q = w.rx_byte;
        if (frame_len != BYTE_COUNT_MAX) frame_len++;
        if (w.last_byte) begin
          close_poll(frame_len == FRAME_BYTES && frame_addr_hit && frame_crc == 16'h0000,
                     w.server_control);
        end
      end
      ACT_MISSING: close_poll(1'b0, w.server_control);
      ACT_TICK: tick_count++;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MISMATCH_PRINT_MAX) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Frame builders
  function automatic byte_q_t with_crc(input byte_q_t body);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = mb_crc_byte(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    return body;
  endfunction

  function automatic byte_q_t good_reply(input logic [7:0] addr, input logic [15:0] speed);
    byte_q_t body;
    body = '{addr, READ_FUNC, REPLY_DATA_LEN, speed[15:8], speed[7:0]};
    return with_crc(body);
  endfunction

  // Speeds cluster on the Beaufort edges and the alarm edge
  function automatic logic [15:0] pick_speed();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'(LEVEL_LIMIT[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1);
    if (r < 7) return 16'($urandom_range(0, 400));
    if (r < 9) return 16'(LEVEL_LIMIT[alarm_slot()] + $urandom_range(0, 2) - 1);
    return 16'($urandom);
  endfunction

  task automatic send_bytes(input byte_q_t b, input bit mark_end, input bit tick_noise);
    in_word_t w;
    foreach (b[i]) begin
      if (tick_noise && $urandom_range(0, 5) == 0) send_other(ACT_TICK);
      w.action = ACT_BYTE;
      w.rx_byte = b[i];
      w.last_byte = mark_end && (i == b.size() - 1);
      w.server_control = 1'($urandom_range(0, 1));
      pending_words.push_back(w);
      queued_count++;
    end
  endtask

  task automatic send_other(input logic [1:0] act);
    in_word_t w;
    w.action = act;
    w.rx_byte = 8'($urandom);
    w.last_byte = 1'($urandom_range(0, 1));
    w.server_control = 1'($urandom_range(0, 1));
    pending_words.push_back(w);
    if (act != ACT_IGNORED) queued_count++;
  endtask

  // Mostly well-formed replies with random speeds, plus broken frames and noise
  task automatic queue_random_traffic(input int count);
    int      stop_at;
    int      r;
    int      n;
    byte_q_t b;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        send_bytes(good_reply(cfg_dev_addr, pick_speed()), 1'b1, $urandom_range(0, 3) == 0);
      end else if (r < 66) begin
        send_other(ACT_MISSING);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 24)) send_other(ACT_TICK);
      end else if (r < 84) begin
        // corrupted bit anywhere in the frame
        b = good_reply(cfg_dev_addr, pick_speed());
        n = $urandom_range(0, FRAME_BYTES - 1);
        b[n] = b[n] ^ (8'h01 << $urandom_range(0, 7));
        send_bytes(b, 1'b1, 1'b0);
      end else if (r < 88) begin
        // reply from another slave, CRC intact
        send_bytes(good_reply(cfg_dev_addr ^ 8'($urandom_range(1, 255)), pick_speed()),
                   1'b1, 1'b0);
      end else if (r < 92) begin
        // wrong length, CRC intact where there is room for one
        n = $urandom_range(1, 12);
        if (n == FRAME_BYTES) n++;
        b.delete();
        if (n >= 3) begin
          b.push_back(cfg_dev_addr);
          repeat (n - 3) b.push_back(8'($urandom));
          b = with_crc(b);
        end else begin
          repeat (n) b.push_back(8'($urandom));
        end
        send_bytes(b, 1'b1, 1'b0);
      end else if (r < 96) begin
        // reply cut off, then reported missing
        b = good_reply(cfg_dev_addr, pick_speed());
        n = $urandom_range(1, FRAME_BYTES - 1);
        send_bytes(b[0:n-1], 1'b0, 1'b0);
        send_other(ACT_MISSING);
      end else if ($urandom_range(0, 1)) begin
        send_other(ACT_IGNORED);
      end else begin
        send_bytes('{8'($urandom)}, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEV_ADDR:   cfg_dev_addr = value[7:0];
      CFG_ALARM_IDX:  cfg_alarm_idx = value[3:0];
      CFG_HOLD_TICKS: cfg_hold_ticks = value;
      default: ;
    endcase
  endtask

  // Wait for every word to go in and every report to come out
  task automatic await_quiet();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) void'(pending_words.pop_front());
    drive_valid = 1'b0;
    if (!rst_ni) begin
      drive_valid = 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      drive_valid = 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
    end else if (pending_words.size() != 0) begin
      drive_valid = 1'b1;
      s_axis_tdata <= {7'd0, pending_words[0].server_control, pending_words[0].rx_byte};
      s_axis_tuser <= pending_words[0].action;
      s_axis_tlast <= pending_words[0].last_byte;
      if (burst_left == 0) burst_left = $urandom_range(1, 24);
      burst_left--;
      if (burst_left == 0) begin
        gap_left = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
    s_axis_tvalid <= drive_valid;
  end

  // Receiver: randomly chosen stall patterns of random length, plus long holds
  always @(posedge clk_i) begin
    take_next = 1'b0;
    if (rst_ni) begin
      if (long_hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (pattern_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
      end else begin
        case (stall_mode)
          0: take_next = 1'b1;
          1: take_next = 1'($urandom_range(0, 1));
          2: take_next = ($urandom_range(0, 9) != 0);
          default: take_next = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
    m_axis_tready <= take_next;
  end

  // Prediction on each accepted word, check on each accepted report
  always @(posedge clk_i) begin
    in_word_t  w;
    out_word_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      w.action = s_axis_tuser;
      w.rx_byte = s_axis_tdata[7:0];
      w.last_byte = s_axis_tlast;
      w.server_control = s_axis_tdata[8];
      step_wind_model(w);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("report with nothing expected: %h", m_axis_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[0] !== want.sensor_present)
          flag_mismatch($sformatf("sensor_present %b, want %b", m_axis_tdata[0],
                                  want.sensor_present));
        if (m_axis_tdata[16:1] !== want.speed_tenths)
          flag_mismatch($sformatf("speed_tenths %0d, want %0d", m_axis_tdata[16:1],
                                  want.speed_tenths));
        if (m_axis_tdata[20:17] !== want.beaufort_level)
          flag_mismatch($sformatf("beaufort_level %0d, want %0d", m_axis_tdata[20:17],
                                  want.beaufort_level));
        if (m_axis_tdata[21] !== want.alarm_mode)
          flag_mismatch($sformatf("alarm_mode %b, want %b", m_axis_tdata[21],
                                  want.alarm_mode));
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    byte_q_t b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values: 10.8 m/s edge, missing reply,
    // cut-off frame, top speed, tick and an ignored word
    send_bytes(good_reply(DEV_ADDR_RESET, 16'd108), 1'b1, 1'b0);
    send_other(ACT_MISSING);
    b = good_reply(DEV_ADDR_RESET, 16'd107);
    send_bytes(b[0:1], 1'b0, 1'b0);
    send_other(ACT_MISSING);
    send_bytes(good_reply(DEV_ADDR_RESET, 16'hFFFF), 1'b1, 1'b0);
    send_other(ACT_TICK);
    send_other(ACT_IGNORED);
    await_quiet();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          write_register(CFG_DEV_ADDR, 32'h00);
          write_register(CFG_ALARM_IDX, 32'd0);
          write_register(CFG_HOLD_TICKS, 32'd0);
        end
        1: begin
          write_register(CFG_DEV_ADDR, 32'hFF);
          write_register(CFG_ALARM_IDX, 32'(MAX_ALARM_IDX));
          write_register(CFG_HOLD_TICKS, 32'd5);
        end
        2: begin
          // index beyond the table saturates; deadline wraps
          write_register(CFG_DEV_ADDR, 32'($urandom_range(0, 255)));
          write_register(CFG_ALARM_IDX, 32'hF);
          write_register(CFG_HOLD_TICKS, 32'hFFFF_FFFF);
        end
        3: begin
          write_register(CFG_ALARM_IDX, 32'($urandom_range(0, 11)));
          write_register(CFG_HOLD_TICKS, 32'hFFFF_FFFF - 32'($urandom_range(0, 40)));
        end
        default: begin
          write_register(CFG_DEV_ADDR, 32'($urandom_range(0, 255)));
          write_register(CFG_ALARM_IDX, 32'($urandom_range(0, 11)));
          write_register(CFG_HOLD_TICKS, 32'($urandom_range(0, 30)));
        end
      endcase
      sender_steady = ($urandom_range(0, 3) == 0);
      queue_random_traffic(PHASE_WORDS);
      // over-long reply pushes the byte counter into saturation
      if (p == 2) begin
        b.delete();
        b.push_back(cfg_dev_addr);
        repeat (258) b.push_back(8'($urandom));
        send_bytes(with_crc(b), 1'b1, 1'b0);
      end
      if (p == 1 || p == 5) long_hold_req = 1'b1;
      await_quiet();
    end

    if (expected_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wrca_pkg.sv
sv/wrca_in_stage.sv
sv/wrca_frame_check.sv
sv/wrca_alarm.sv
sv/wind_reply_check_and_alarm.sv
verif/tb_top.sv
